// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define TKS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: property failed");

// expression must never be true outside reset
`define TKS_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("%m: forbidden condition seen");

`endif

// ===== rtl/core/tksel_pkg.sv =====
// ----------------------------------------------------------------------------
// tksel_pkg
// Types and constants shared by the top-k score selector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tksel_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int MAX_PICKS   = 16;

  localparam int SCORE_W = 16;
  localparam int POS_W   = 8;
  localparam int PCNT_W  = 5;
  localparam int IDX_W   = $clog2(MAX_ENTRIES);
  localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int RND_W   = $clog2(MAX_PICKS + 1);

  localparam logic signed [SCORE_W-1:0] HIGH_BOUND = 16'sd16700;
  localparam logic signed [SCORE_W-1:0] LOW_BOUND  = -16'sd16700;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PICK_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PICK_LOWEST = 2'd1;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score_value;
    logic                      end_of_list;
  } tksel_in_t;

  typedef struct packed {
    logic [POS_W-1:0] chosen_position;
    logic             final_pick;
  } tksel_out_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_EMIT
  } tksel_st_t;

  typedef struct packed {
    logic             busy;
    logic             pop;
    logic             emit_final;
    logic [CNT_W-1:0] count;
  } tksel_stat_t;

endpackage

// ===== rtl/core/tksel_front.sv =====
// ----------------------------------------------------------------------------
// tksel_front
// Input stage: registers each transfer and hands it to the item queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tksel_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tksel_pkg::tksel_in_t in_data,
  input  logic                q_full,
  output logic                q_push,
  output tksel_pkg::tksel_in_t q_data
);
  import tksel_pkg::*;

  logic      fr_vld_r;
  logic      fr_vld_nxt;
  tksel_in_t fr_data_r;
  logic      in_take;

  assign q_push   = fr_vld_r && !q_full;
  assign in_stall = fr_vld_r && q_full;
  assign in_take  = in_valid && !in_stall;
  assign q_data   = fr_data_r;

  always_comb begin
    fr_vld_nxt = fr_vld_r;
    if (in_take) begin
      fr_vld_nxt = 1'b1;
    end else if (q_push) begin
      fr_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_vld_r <= 1'b0;
    end else begin
      fr_vld_r <= fr_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      fr_data_r <= in_data;
    end
  end

endmodule

// ===== rtl/core/tksel_queue.sv =====
// ----------------------------------------------------------------------------
// tksel_queue
// Short FIFO between the input stage and the selection engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tksel_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  tksel_pkg::tksel_in_t push_data,
  output logic                 full,
  input  logic                 pop,
  output logic                 not_empty,
  output tksel_pkg::tksel_in_t pop_data
);
  import tksel_pkg::*;

  tksel_in_t          slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_PTR_W:0]   fill_r;
  logic [Q_PTR_W:0]   fill_nxt;
  logic               do_push;
  logic               do_pop;

  assign full      = (fill_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign not_empty = (fill_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = slot_r[rd_ptr_r];

  always_comb begin
    fill_nxt = fill_r;
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/core/tksel_back.sv =====
// ----------------------------------------------------------------------------
// tksel_back
// Selection engine: stores scores, then scans the store once per round and
// reports the best position that was not picked before.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tksel_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_vld,
  input  tksel_pkg::tksel_in_t        q_data,
  output logic                        q_pop,
  input  logic [tksel_pkg::PCNT_W-1:0] cfg_pick_count,
  input  logic                        cfg_pick_lowest,
  output logic                        out_valid,
  input  logic                        out_stall,
  output tksel_pkg::tksel_out_t       out_data,
  output tksel_pkg::tksel_stat_t      stat
);
  import tksel_pkg::*;

  tksel_st_t st_r, st_nxt;

  logic signed [SCORE_W-1:0] mem [MAX_ENTRIES];

  logic [CNT_W-1:0]          count_r;
  logic [CNT_W-1:0]          idx_r;
  logic [RND_W-1:0]          rounds_r;
  logic [RND_W-1:0]          round_r;
  logic [MAX_ENTRIES-1:0]    picked_r;
  logic                      rd_vld_r;
  logic signed [SCORE_W-1:0] rd_data_r;
  logic                      rd_flag_r;
  logic [IDX_W-1:0]          rd_idx_r;
  logic signed [SCORE_W-1:0] best_r;
  logic [IDX_W-1:0]          pos_r;
  logic                      found_r;
  logic                      out_valid_r;
  tksel_out_t                out_data_r;

  logic [RND_W-1:0]          rounds_sat;
  logic                      room;
  logic                      scan_done;
  logic                      can_load;
  logic                      last_round;
  logic                      issue;
  logic                      emit;
  logic                      start;
  logic                      take;
  logic [31:0]               pos_ext;

  // round count saturates at MAX_PICKS
  always_comb begin
    if (int'(cfg_pick_count) > MAX_PICKS) begin
      rounds_sat = RND_W'(MAX_PICKS);
    end else begin
      rounds_sat = RND_W'(cfg_pick_count);
    end
  end

  assign room       = (count_r < CNT_W'(MAX_ENTRIES));
  assign scan_done  = (idx_r >= count_r) && !rd_vld_r;
  assign can_load   = !out_valid_r || !out_stall;
  assign last_round = (({1'b0, round_r} + 1'b1) == {1'b0, rounds_r});
  assign take       = cfg_pick_lowest ? (rd_data_r < best_r) : (rd_data_r >= best_r);
  assign pos_ext    = 32'(pos_r);

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_LOAD: begin
        if (q_vld && q_data.end_of_list && (rounds_sat != '0)) begin
          st_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          st_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (can_load) begin
          st_nxt = last_round ? ST_LOAD : ST_SCAN;
        end
      end
      default: st_nxt = ST_LOAD;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop = 1'b0;
    issue = 1'b0;
    emit  = 1'b0;
    case (st_r)
      ST_LOAD: q_pop = q_vld;
      ST_SCAN: issue = (idx_r < count_r);
      ST_EMIT: emit  = can_load;
      default: begin
        q_pop = 1'b0;
      end
    endcase
    start = q_pop && q_data.end_of_list && (rounds_sat != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_LOAD;
      count_r     <= '0;
      idx_r       <= '0;
      rounds_r    <= '0;
      round_r     <= '0;
      picked_r    <= '0;
      rd_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      rd_vld_r <= issue;

      if (q_pop) begin
        if (q_data.end_of_list && (rounds_sat == '0)) begin
          count_r <= '0;
        end else begin
          count_r <= count_r + CNT_W'(room);
        end
      end else if (emit && last_round) begin
        count_r <= '0;
      end

      if (start) begin
        rounds_r <= rounds_sat;
        round_r  <= '0;
        picked_r <= '0;
      end else if (emit) begin
        round_r <= round_r + 1'b1;
        if (found_r) begin
          picked_r[pos_r] <= 1'b1;
        end
      end

      if (start || emit) begin
        idx_r   <= '0;
        found_r <= 1'b0;
      end else begin
        if (issue) begin
          idx_r <= idx_r + 1'b1;
        end
        if (rd_vld_r && !rd_flag_r && take) begin
          found_r <= 1'b1;
        end
      end

      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // score store: one write port for loading, one registered read for the scan
  always_ff @(posedge clk) begin
    if (q_pop && room) begin
      mem[count_r[IDX_W-1:0]] <= q_data.score_value;
    end
    if (issue) begin
      rd_data_r <= mem[idx_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_flag_r <= picked_r[idx_r[IDX_W-1:0]];
      rd_idx_r  <= idx_r[IDX_W-1:0];
    end
    if (start || emit) begin
      best_r <= cfg_pick_lowest ? HIGH_BOUND : LOW_BOUND;
      pos_r  <= '0;
    end else if (rd_vld_r && !rd_flag_r && take) begin
      best_r <= rd_data_r;
      pos_r  <= rd_idx_r;
    end
    if (emit) begin
      out_data_r.chosen_position <= pos_ext[POS_W-1:0];
      out_data_r.final_pick      <= last_round;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign stat.busy       = (st_r != ST_LOAD);
  assign stat.pop        = q_pop;
  assign stat.emit_final = emit && last_round;
  assign stat.count      = count_r;

endmodule

// ===== rtl/core/top_k_score_selector_top.sv =====
// ----------------------------------------------------------------------------
// top_k_score_selector_top
// Top-k score selector: loads a list of scores, then reports best positions.
// ----------------------------------------------------------------------------
// Scores are taken one per cycle, while no selection runs, into a 256-entry
// store until a transfer with end_of_list. The selection then runs pick_count
// rounds (at most 16); each round scans the loaded entries through the store's
// single read port, one entry per cycle, and then hands its best position to
// the output register, waiting while the output stalls. New items collect in
// a short queue during that time and are taken once the last position of the
// run has been handed to the output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module top_k_score_selector_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  tksel_pkg::tksel_in_t           in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output tksel_pkg::tksel_out_t          out_data,
  input  logic                           cfg_we,
  input  logic [tksel_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tksel_pkg::PCNT_W-1:0]   cfg_wdata
);
  import tksel_pkg::*;

  logic [PCNT_W-1:0] pick_count_r;
  logic              pick_lowest_r;

  logic        q_push;
  tksel_in_t   q_push_data;
  logic        q_full;
  logic        q_pop;
  logic        q_vld;
  tksel_in_t   q_pop_data;
  tksel_stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pick_count_r  <= PCNT_W'(1);
      pick_lowest_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PICK_COUNT:  pick_count_r  <= cfg_wdata;
        CFG_PICK_LOWEST: pick_lowest_r <= cfg_wdata[0];
        default: begin
          pick_lowest_r <= pick_lowest_r;
        end
      endcase
    end
  end

  tksel_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_push_data)
  );

  tksel_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_vld),
    .pop_data  (q_pop_data)
  );

  tksel_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_vld           (q_vld),
    .q_data          (q_pop_data),
    .q_pop           (q_pop),
    .cfg_pick_count  (pick_count_r),
    .cfg_pick_lowest (pick_lowest_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .stat            (stat)
  );

  // no item is taken from the queue while a selection runs
  `TKS_ASSERT_NEVER(a_no_pop_busy, clk, rst_n, stat.busy && stat.pop)
  // the list is emptied once the last position of a run is issued
  `TKS_ASSERT(a_count_cleared, clk, rst_n, stat.emit_final |=> stat.count == '0)
  // the fill count never passes the store depth
  `TKS_ASSERT(a_count_bound, clk, rst_n, stat.count <= CNT_W'(MAX_ENTRIES))

endmodule
